[hw/rtl/lzsd_pkg.sv]
// ----------------------------------------------------------------------------
// lzsd_pkg
// Shared constants and types of the LZSS stream decompressor: item layouts,
// parser and copy engine states, command format and error codes.
// ----------------------------------------------------------------------------
package lzsd_pkg;

  localparam int HISTORY_DEPTH    = 65536;
  localparam int HIST_AW          = $clog2(HISTORY_DEPTH);
  localparam int CNT_W            = HIST_AW + 1;
  localparam int DIST_W           = 16;
  localparam int BYTES_PER_RESULT = 8;
  localparam int CMD_DEPTH        = 4;
  localparam int CMD_AW           = $clog2(CMD_DEPTH);
  localparam int OUT_DEPTH        = 4;
  localparam int OUT_AW           = $clog2(OUT_DEPTH);

  localparam logic [7:0] MATCH_FLAG = 8'd1;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_DIST  = 2'd1;
  localparam logic [1:0] ERR_TRUNC = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_last;
  } in_t;

  typedef struct packed {
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic        run_last;
    logic        stream_end;
    logic [1:0]  error_code;
  } out_t;

  typedef enum logic [2:0] {
    PH_FLAG,
    PH_DIST_HI,
    PH_DIST_LO,
    PH_LEN,
    PH_LIT
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_LIT,
    CMD_COPY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [7:0]        data;
    logic [DIST_W-1:0] match_dist;
    logic [1:0]        err;
    logic              last;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_COPY
  } back_state_t;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_LIT,
    SRC_MEM,
    SRC_FWD
  } src_sel_t;

endpackage

[hw/rtl/lzsd_front.sv]
// ----------------------------------------------------------------------------
// lzsd_front
// Token parser: classifies each compressed byte, checks match distances
// against the bytes produced so far and queues commands for the copy engine.
// ----------------------------------------------------------------------------
module lzsd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  lzsd_pkg::in_t in_item,
  output logic          cmd_valid,
  output lzsd_pkg::cmd_t cmd,
  input  logic          cmd_pop
);
  import lzsd_pkg::*;

  phase_t            phase, phase_next;
  logic [DIST_W-1:0] distance, distance_next;
  logic [CNT_W-1:0]  produced, produced_next;
  logic [CNT_W-1:0]  produced_sum;
  logic              accept;
  logic              make_cmd;
  cmd_t              new_cmd;

  cmd_t              queue [CMD_DEPTH];
  logic [CMD_AW-1:0] wr_ptr, rd_ptr;
  logic [CMD_AW:0]   count;
  logic              q_push, q_pop;

  assign full   = (count == (CMD_AW + 1)'(CMD_DEPTH));
  assign accept = push && !full;

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_FLAG:    phase_next = (in_item.in_byte == MATCH_FLAG) ? PH_DIST_HI : PH_LIT;
      PH_DIST_HI: phase_next = PH_DIST_LO;
      PH_DIST_LO: phase_next = PH_LEN;
      PH_LEN:     phase_next = PH_FLAG;
      PH_LIT:     phase_next = PH_FLAG;
      default:    phase_next = PH_FLAG;
    endcase
    if (in_item.stream_last) begin
      phase_next = PH_FLAG;
    end
  end

  always_comb begin
    distance_next      = distance;
    produced_next      = produced;
    produced_sum       = CNT_W'(produced + CNT_W'(in_item.in_byte));
    make_cmd           = 1'b0;
    new_cmd.kind       = CMD_NONE;
    new_cmd.data       = in_item.in_byte;
    new_cmd.match_dist = distance;
    new_cmd.err        = ERR_NONE;
    new_cmd.last       = in_item.stream_last;
    unique case (phase)
      PH_FLAG: begin
        if (in_item.stream_last) begin
          new_cmd.err = ERR_TRUNC;
        end
      end
      PH_DIST_HI: begin
        distance_next = {in_item.in_byte, 8'h00};
        if (in_item.stream_last) begin
          new_cmd.err = ERR_TRUNC;
        end
      end
      PH_DIST_LO: begin
        distance_next = {distance[15:8], in_item.in_byte};
        if (in_item.stream_last) begin
          new_cmd.err = ERR_TRUNC;
        end
      end
      PH_LEN: begin
        make_cmd = 1'b1;
        if (distance == '0 || CNT_W'(distance) > produced) begin
          new_cmd.err = ERR_DIST;
        end else begin
          new_cmd.kind = CMD_COPY;
          if (produced_sum > CNT_W'(HISTORY_DEPTH)) begin
            produced_next = CNT_W'(HISTORY_DEPTH);
          end else begin
            produced_next = produced_sum;
          end
        end
      end
      PH_LIT: begin
        make_cmd     = 1'b1;
        new_cmd.kind = CMD_LIT;
        if (produced != CNT_W'(HISTORY_DEPTH)) begin
          produced_next = CNT_W'(produced + 1'b1);
        end
      end
      default: begin
      end
    endcase
    if (in_item.stream_last) begin
      make_cmd      = 1'b1;
      distance_next = '0;
      produced_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_FLAG;
      distance <= '0;
      produced <= '0;
    end else if (accept) begin
      phase    <= phase_next;
      distance <= distance_next;
      produced <= produced_next;
    end
  end

  // command queue
  assign q_push    = accept && make_cmd;
  assign cmd_valid = (count != '0);
  assign q_pop     = cmd_pop && cmd_valid;
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (q_push) begin
      queue[wr_ptr] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_push) begin
        wr_ptr <= CMD_AW'(wr_ptr + 1'b1);
      end
      if (q_pop) begin
        rd_ptr <= CMD_AW'(rd_ptr + 1'b1);
      end
      count <= (CMD_AW + 1)'(count + q_push - q_pop);
    end
  end

endmodule

[hw/rtl/lzsd_back.sv]
// ----------------------------------------------------------------------------
// lzsd_back
// Copy engine: executes literal and match commands one byte per cycle while
// out_room holds, reading the history ring, and packs bytes into results.
// ----------------------------------------------------------------------------
module lzsd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  lzsd_pkg::cmd_t cmd,
  output logic           cmd_pop,
  input  logic           out_room,
  output logic           res_push,
  output lzsd_pkg::out_t res
);
  import lzsd_pkg::*;

  back_state_t        state, state_next;
  logic [DIST_W-1:0]  c_dist;
  logic [7:0]         c_remain;
  logic               c_last;
  logic [HIST_AW-1:0] ip;
  logic [HIST_AW-1:0] wp;

  logic               iss_valid;
  src_sel_t           iss_src;
  logic               iss_close;
  logic               iss_last;
  logic [1:0]         iss_err;
  logic [HIST_AW-1:0] rd_addr;
  logic               load_copy;

  logic               s1_valid;
  src_sel_t           s1_src;
  logic [7:0]         s1_lit;
  logic               s1_close;
  logic               s1_last;
  logic [1:0]         s1_err;

  logic [7:0]         hist [HISTORY_DEPTH];
  logic [7:0]         mem_q;
  logic [7:0]         last_byte;
  logic [63:0]        acc, acc_after;
  logic [3:0]         cnt, cnt_after;
  logic [7:0]         byte_v;
  logic               has_byte;

  assign load_copy = (cmd.kind == CMD_COPY) && (cmd.data != '0);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid && out_room && load_copy) begin
          state_next = BK_COPY;
        end
      end
      BK_COPY: begin
        if (out_room && c_remain == 8'd1) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop   = 1'b0;
    iss_valid = 1'b0;
    iss_src   = SRC_NONE;
    iss_close = 1'b0;
    iss_last  = 1'b0;
    iss_err   = ERR_NONE;
    rd_addr   = HIST_AW'(DIST_W'(ip) - c_dist);
    unique case (state)
      BK_IDLE: begin
        if (cmd_valid && out_room) begin
          cmd_pop = 1'b1;
          if (!load_copy) begin
            iss_valid = 1'b1;
            iss_src   = (cmd.kind == CMD_LIT) ? SRC_LIT : SRC_NONE;
            iss_close = 1'b1;
            iss_last  = cmd.last;
            iss_err   = cmd.err;
          end
        end
      end
      BK_COPY: begin
        if (out_room) begin
          iss_valid = 1'b1;
          iss_src   = (c_dist == DIST_W'(1)) ? SRC_FWD : SRC_MEM;
          iss_close = (c_remain == 8'd1);
          iss_last  = c_last;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      ip       <= '0;
      s1_valid <= 1'b0;
    end else begin
      state    <= state_next;
      s1_valid <= iss_valid;
      if (iss_valid && iss_close && iss_last) begin
        ip <= '0;
      end else if (iss_valid && iss_src != SRC_NONE) begin
        ip <= HIST_AW'(ip + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_IDLE && cmd_pop && load_copy) begin
      c_dist   <= cmd.match_dist;
      c_remain <= cmd.data;
      c_last   <= cmd.last;
    end else if (state == BK_COPY && out_room) begin
      c_remain <= 8'(c_remain - 1'b1);
    end
    s1_src   <= iss_src;
    s1_lit   <= cmd.data;
    s1_close <= iss_close;
    s1_last  <= iss_last;
    s1_err   <= iss_err;
  end

  // history ring
  always_ff @(posedge clk) begin
    if (iss_valid && iss_src == SRC_MEM) begin
      mem_q <= hist[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (has_byte) begin
      hist[wp]  <= byte_v;
      last_byte <= byte_v;
    end
  end

  // packing
  always_comb begin
    unique case (s1_src)
      SRC_LIT:  byte_v = s1_lit;
      SRC_MEM:  byte_v = mem_q;
      SRC_FWD:  byte_v = last_byte;
      default:  byte_v = '0;
    endcase
    has_byte  = s1_valid && (s1_src != SRC_NONE);
    cnt_after = 4'(cnt + has_byte);
    acc_after = acc;
    for (int i = 0; i < BYTES_PER_RESULT; i++) begin
      if (has_byte && cnt == 4'(i)) begin
        acc_after[8*i +: 8] = byte_v;
      end
    end
    res_push = s1_valid && ((cnt_after == 4'(BYTES_PER_RESULT)) ||
               (s1_close && (cnt_after != '0 || s1_last || s1_err != ERR_NONE)));
    res.out_bytes  = acc_after;
    res.byte_count = cnt_after;
    res.run_last   = s1_close;
    res.stream_end = s1_close && s1_last;
    res.error_code = s1_err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      cnt <= '0;
      wp  <= '0;
    end else begin
      if (res_push) begin
        acc <= '0;
        cnt <= '0;
      end else begin
        acc <= acc_after;
        cnt <= cnt_after;
      end
      if (s1_valid && s1_close && s1_last) begin
        wp <= '0;
      end else if (has_byte) begin
        wp <= HIST_AW'(wp + 1'b1);
      end
    end
  end

endmodule

[hw/rtl/lzsd_out_queue.sv]
// ----------------------------------------------------------------------------
// lzsd_out_queue
// Result queue between the copy engine and the consumer; reports room for
// the engine so that an issued byte can always land.
// ----------------------------------------------------------------------------
module lzsd_out_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           res_push,
  input  lzsd_pkg::out_t res,
  output logic           out_room,
  output logic           empty,
  input  logic           pop,
  output lzsd_pkg::out_t out_item
);
  import lzsd_pkg::*;

  out_t              queue [OUT_DEPTH];
  logic [OUT_AW-1:0] wr_ptr, rd_ptr;
  logic [OUT_AW:0]   count;
  logic              q_pop;

  assign empty    = (count == '0);
  assign q_pop    = pop && !empty;
  assign out_item = queue[rd_ptr];
  // one byte in flight plus one being issued
  assign out_room = (count <= (OUT_AW + 1)'(OUT_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (res_push) begin
      queue[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (res_push) begin
        wr_ptr <= OUT_AW'(wr_ptr + 1'b1);
      end
      if (q_pop) begin
        rd_ptr <= OUT_AW'(rd_ptr + 1'b1);
      end
      count <= (OUT_AW + 1)'(count + res_push - q_pop);
    end
  end

endmodule

[hw/rtl/lzss_stream_decompressor.sv]
// path: a literal or closing result passes the command queue, the s1 stage and
//   the result queue; header bytes cause no engine work unless they end a stream
// throughput: one input byte per cycle while the 4-entry command queue has room;
//   the copy engine takes no new command while a match is copying; a match of
//   distance 1 reuses the last byte, others read the ring once per copied byte
// reset: synchronous, clears parser, queues and pointers; the history ring
//   is not cleared
// ----------------------------------------------------------------------------
// lzss_stream_decompressor
// LZSS token stream decompressor with a 64 KiB history ring and results of
// up to eight bytes.
// ----------------------------------------------------------------------------
module lzss_stream_decompressor (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  lzsd_pkg::in_t  in_item,
  output logic           empty,
  input  logic           pop,
  output lzsd_pkg::out_t out_item
);
  import lzsd_pkg::*;

  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  logic out_room;
  logic res_push;
  out_t res;

  lzsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  lzsd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_room  (out_room),
    .res_push  (res_push),
    .res       (res)
  );

  lzsd_out_queue u_out_queue (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .out_room (out_room),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule

[hw/rtl/lzsd_checker.sv]
// ----------------------------------------------------------------------------
// lzsd_checker
// Port-level checks of the decompressor's result stream, bound to the top.
// ----------------------------------------------------------------------------
module lzsd_checker (
  input logic           clk,
  input logic           rst,
  input logic           empty,
  input logic           pop,
  input lzsd_pkg::out_t out_item
);
  import lzsd_pkg::*;

  // queue comes up empty after reset
  a_empty_after_reset: assert property (@(posedge clk) $past(rst) |-> empty)
    else $error("result queue not empty after reset");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> out_item.byte_count <= 4'(BYTES_PER_RESULT))
    else $error("byte count beyond result width");

  a_error_no_bytes: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.error_code != ERR_NONE) |-> out_item.byte_count == '0)
    else $error("error result carries bytes");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.stream_end) |-> out_item.run_last)
    else $error("stream end not on last result of its byte");

  a_pop_waits: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("waiting result dropped without transfer");

endmodule

bind lzss_stream_decompressor lzsd_checker u_lzsd_checker (.*);

[test/lzss_stream_decompressor_tb.sv]
// ----------------------------------------------------------------------------
// lzss_stream_decompressor_tb
// Feeds LZSS token streams into the decompressor: literals, matches with and
// without overlap, empty matches, bad distances and streams cut short
// mid-token. A local decoder keeps its own history ring and works out the
// result words, which the monitor checks in order. Both sides stall at
// random, and the receiver once holds off long enough for the input to stall.
// ----------------------------------------------------------------------------
module lzss_stream_decompressor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lzsd_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 470;
  localparam int HOLD_CYCLES  = 300;

  typedef struct {
    in_t item;
    bit  drain;
  } stim_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  in_t  in_item = '0;
  logic full;
  logic empty;
  out_t out_item;

  stim_t stream_q[$];
  out_t  decoded_q[$];
  bit    drain_next;

  logic [7:0]  hist_mem [HISTORY_DEPTH];
  phase_t      dec_phase = PH_FLAG;
  logic [15:0] dec_dist = '0;
  logic [15:0] dec_wptr = '0;
  int unsigned dec_made;

  int  cycles;
  int  errors;
  int  sent_cnt;
  int  words_seen;
  int  streams_seen;
  int  full_cycles;
  int  error_words;
  bit  in_fired;
  int  hold_left;
  bit  hold_done;

  lzss_stream_decompressor uut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report(string msg);
    errors++;
    if (errors <= 30) $display("mismatch: %s", msg);
  endtask

  function automatic logic [7:0] keep_byte(logic [7:0] b);
    hist_mem[dec_wptr] = b;
    dec_wptr = dec_wptr + 16'd1;
    if (dec_made < HISTORY_DEPTH) dec_made++;
    return b;
  endfunction

  task automatic decode_byte(in_t it);
    logic [7:0]  run [$];
    logic [1:0]  err;
    logic [15:0] src;
    int          nres;
    int          pos;
    int          cnt;
    out_t        w;
    err = ERR_NONE;
    case (dec_phase)
      PH_FLAG: dec_phase = (it.in_byte == MATCH_FLAG) ? PH_DIST_HI : PH_LIT;
      PH_DIST_HI: begin
        dec_dist = {it.in_byte, 8'h00};
        dec_phase = PH_DIST_LO;
      end
      PH_DIST_LO: begin
        dec_dist[7:0] = it.in_byte;
        dec_phase = PH_LEN;
      end
      PH_LEN: begin
        dec_phase = PH_FLAG;
        if (dec_dist == 16'd0 || dec_dist > dec_made) begin
          err = ERR_DIST;
        end else begin
          for (int i = 0; i < it.in_byte; i++) begin
            src = dec_wptr - dec_dist;
            run.push_back(keep_byte(hist_mem[src]));
          end
        end
      end
      PH_LIT: begin
        run.push_back(keep_byte(it.in_byte));
        dec_phase = PH_FLAG;
      end
      default: dec_phase = PH_FLAG;
    endcase
    if (it.stream_last && dec_phase != PH_FLAG) err = ERR_TRUNC;
    nres = (run.size() + BYTES_PER_RESULT - 1) / BYTES_PER_RESULT;
    if (nres == 0 && (err != ERR_NONE || it.stream_last)) nres = 1;
    pos = 0;
    for (int k = 0; k < nres; k++) begin
      cnt = run.size() - pos;
      if (cnt > BYTES_PER_RESULT) cnt = BYTES_PER_RESULT;
      w = '0;
      for (int i = 0; i < cnt; i++) w.out_bytes[8*i +: 8] = run[pos + i];
      pos += cnt;
      w.byte_count = cnt[3:0];
      w.run_last = (k == nres - 1);
      w.stream_end = w.run_last && it.stream_last;
      w.error_code = err;
      decoded_q.push_back(w);
    end
    if (it.stream_last) begin
      dec_phase = PH_FLAG;
      dec_dist = '0;
      dec_wptr = '0;
      dec_made = 0;
    end
  endtask

  task automatic check_word(out_t got);
    out_t want;
    if (decoded_q.size() == 0) begin
      report($sformatf("result %0d not expected: %h", words_seen, got));
      return;
    end
    want = decoded_q.pop_front();
    if (got.out_bytes !== want.out_bytes)
      report($sformatf("result %0d out_bytes %h, expected %h", words_seen,
                       got.out_bytes, want.out_bytes));
    if (got.byte_count !== want.byte_count)
      report($sformatf("result %0d byte_count %0d, expected %0d", words_seen,
                       got.byte_count, want.byte_count));
    if (got.run_last !== want.run_last)
      report($sformatf("result %0d run_last %b, expected %b", words_seen,
                       got.run_last, want.run_last));
    if (got.stream_end !== want.stream_end)
      report($sformatf("result %0d stream_end %b, expected %b", words_seen,
                       got.stream_end, want.stream_end));
    if (got.error_code !== want.error_code)
      report($sformatf("result %0d error_code %0d, expected %0d", words_seen,
                       got.error_code, want.error_code));
  endtask

  task automatic put(logic [7:0] b, logic last);
    stim_t s;
    s.item.in_byte = b;
    s.item.stream_last = last;
    s.drain = drain_next;
    drain_next = 0;
    stream_q.push_back(s);
  endtask

  task automatic put_literal(logic [7:0] b, logic last);
    logic [7:0] flag;
    do flag = 8'($urandom_range(0, 255)); while (flag == MATCH_FLAG);
    put(flag, 1'b0);
    put(b, last);
  endtask

  task automatic put_match(logic [15:0] distance, logic [7:0] len, logic last);
    put(MATCH_FLAG, 1'b0);
    put(distance[15:8], 1'b0);
    put(distance[7:0], 1'b0);
    put(len, last);
  endtask

  // transfer monitor, decoder and result checks
  always @(posedge clk) begin
    cycles++;
    in_fired = 1'b0;
    if (!rst) begin
      if (push && full) full_cycles++;
      if (push && !full) begin
        in_fired = 1'b1;
        sent_cnt++;
        if (in_item.stream_last) streams_seen++;
        decode_byte(in_item);
      end
      if (pop && !empty) begin
        if (out_item.error_code != ERR_NONE) error_words++;
        check_word(out_item);
        words_seen++;
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("lzss_stream_decompressor_tb NOT OK");
      $finish;
    end
  end

  // input driver
  always @(negedge clk) begin
    bit offer;
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (in_fired) void'(stream_q.pop_front());
      offer = stream_q.size() != 0;
      if (offer && stream_q[0].drain && decoded_q.size() != 0) offer = 0;
      if (offer && !(sent_cnt >= 300 && sent_cnt < 380) && $urandom_range(0, 99) < 12)
        offer = 0;
      push <= offer;
      if (offer) in_item <= stream_q[0].item;
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (!hold_done && sent_cnt >= 60) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= (sent_cnt >= 300 && sent_cnt < 380) || $urandom_range(0, 99) >= 12;
      end
    end
  end

  initial begin
    int unsigned n_tok;
    int unsigned made;
    int unsigned r;
    int unsigned k;
    logic [15:0] distance;
    logic [7:0]  len;
    logic        fin;
    logic [7:0]  flag;
    bit          drain_set;

    // directed: extreme literals, long overlapping copy, empty match,
    // zero and out-of-range distances, stream cut after a match flag
    put(8'h00, 1'b0);
    put(8'h00, 1'b0);
    put(8'hFF, 1'b0);
    put(8'hFF, 1'b0);
    put_match(16'd1, 8'd255, 1'b0);
    put_match(16'd2, 8'd0, 1'b0);
    put_match(16'd0, 8'd5, 1'b0);
    put_match(16'hFFFF, 8'd0, 1'b0);
    put(MATCH_FLAG, 1'b1);
    // literal closing a stream, then an empty match closing a stream
    put(8'h02, 1'b0);
    put(8'h5A, 1'b1);
    put(8'h80, 1'b0);
    put(8'h3C, 1'b0);
    put_match(16'd1, 8'd0, 1'b1);

    drain_set = 0;
    while (stream_q.size() < RANDOM_ITEMS - 24) begin
      if (!drain_set && stream_q.size() > 250) begin
        drain_next = 1;
        drain_set = 1;
      end
      n_tok = $urandom_range(1, 24);
      // at most four bytes per token
      if (n_tok > (RANDOM_ITEMS - stream_q.size()) / 4)
        n_tok = (RANDOM_ITEMS - stream_q.size()) / 4;
      made = 0;
      for (int t = 0; t < n_tok; t++) begin
        fin = (t == n_tok - 1);
        r = $urandom_range(0, 99);
        if (fin && r < 10) begin
          // stream cut mid-token
          if ($urandom_range(0, 3) == 0) begin
            do flag = 8'($urandom_range(0, 255)); while (flag == MATCH_FLAG);
            put(flag, 1'b1);
          end else begin
            k = $urandom_range(1, 3);
            put(MATCH_FLAG, k == 1);
            for (int j = 1; j < k; j++) put(8'($urandom_range(0, 255)), j == k - 1);
          end
        end else if (made == 0 || r < 55) begin
          put_literal(8'($urandom_range(0, 255)), fin);
          made++;
        end else begin
          if (r < 65) begin
            distance = 16'($urandom_range(0, 65535));
          end else if (r < 85 && made > 64) begin
            distance = 16'($urandom_range(1, 64));
          end else begin
            distance = 16'($urandom_range(1, made));
          end
          if ($urandom_range(0, 9) == 0) len = 8'($urandom_range(0, 255));
          else len = 8'($urandom_range(0, 16));
          put_match(distance, len, fin);
          if (distance != 0 && distance <= made) made += len;
        end
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (stream_q.size() != 0 || decoded_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("%0d input bytes in %0d streams, %0d result words (%0d with errors)",
             sent_cnt, streams_seen, words_seen, error_words);
    $display("input stalled on full for %0d cycles, %0d cycles total",
             full_cycles, cycles);
    if (errors == 0) begin
      $display("lzss_stream_decompressor_tb OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("lzss_stream_decompressor_tb NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/lzsd_pkg.sv
hw/rtl/lzsd_front.sv
hw/rtl/lzsd_back.sv
hw/rtl/lzsd_out_queue.sv
hw/rtl/lzss_stream_decompressor.sv
hw/rtl/lzsd_checker.sv
test/lzss_stream_decompressor_tb.sv
